>>> rtl/core/sha256_hash_engine_top_defines.svh
// assertion macros for the sha256 hash engine
// no dependencies
`ifndef SHA256_HASH_ENGINE_TOP_DEFINES_SVH
`define SHA256_HASH_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("sha256 check failed");
`define SHA_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("sha256 check failed");
`else
`define SHA_ASSERT(lbl, clk, rst_n, prop)
`define SHA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> rtl/core/sha_pkg.sv
// shared types, constants and functions for the sha256 hash engine
// no dependencies
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_item;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } sha_state_e;

  // datapath commands
  typedef struct packed {
    logic       write_byte;  // write byte at pos
    logic [7:0] wbyte;
    logic       count_inc;
    logic       load_wv;     // chain -> working vars
    logic       do_round;
    logic       fold;        // chain += working vars
    logic       clear_tail;  // pad byte at pos, zeros after, length words if len_set
    logic       tail_all;    // zero the whole block, no pad byte
    logic       len_set;
    logic       reset_msg;   // chain and count to initial
    logic       emit;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } sha_stat_t;

  localparam logic [7:0] PAD_BYTE = 8'b1000_0000;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> rtl/core/sha_ctrl.sv
// controller state machine for the sha256 hash engine
// depends on sha_pkg and the defines header
`include "sha256_hash_engine_top_defines.svh"
module sha_ctrl
  import sha_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  sha_in_t   item_i,
  input  sha_stat_t stat_i,
  output logic      busy_o,
  output sha_cmd_t  cmd_o,
  output logic [5:0] round_o,
  output logic [2:0] widx_o
);

  sha_state_e state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] widx_q, widx_d;
  logic       last_q, last_d;   // message end pending
  logic       final_q, final_d; // current compression is the length block
  logic       pad_done_q, pad_done_d; // pad byte already placed in an earlier block
  logic       acc;

  assign acc = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign round_o = rnd_q;
  assign widx_o = widx_q;

  // next state
  always_comb begin
    state_d = state_q;
    rnd_d = rnd_q;
    widx_d = widx_q;
    last_d = last_q;
    final_d = final_q;
    pad_done_d = pad_done_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          last_d = item_i.last_item;
          final_d = 1'b0;
          pad_done_d = 1'b0;
          rnd_d = '0;
          if (item_i.has_byte && stat_i.pos == 6'd63) begin
            state_d = ST_ROUND;
          end else if (item_i.last_item) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // pad at pos; from pos 56 on the length needs a second block
        rnd_d = '0;
        state_d = ST_ROUND;
        pad_done_d = 1'b1;
        final_d = pad_done_q || (stat_i.pos < 6'd56);
        last_d = final_d ? 1'b0 : last_q;
      end
      ST_ROUND: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        widx_d = '0;
        if (final_q) begin
          state_d = ST_EMIT;
        end else if (last_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        widx_d = widx_q + 3'd1;
        if (widx_q == 3'd7) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc && item_i.has_byte) begin
          cmd_o.write_byte = 1'b1;
          cmd_o.wbyte = item_i.data_byte;
          cmd_o.count_inc = 1'b1;
        end
        if (acc && (item_i.has_byte && stat_i.pos == 6'd63)) begin
          cmd_o.load_wv = 1'b1;
        end
      end
      ST_PAD: begin
        cmd_o.clear_tail = 1'b1;
        cmd_o.tail_all = pad_done_q;
        cmd_o.len_set = pad_done_q || (stat_i.pos < 6'd56);
        cmd_o.load_wv = 1'b1;
      end
      ST_ROUND: cmd_o.do_round = 1'b1;
      ST_FOLD:  cmd_o.fold = 1'b1;
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        cmd_o.reset_msg = (widx_q == 3'd7);
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q <= '0;
      widx_q <= '0;
      last_q <= 1'b0;
      final_q <= 1'b0;
      pad_done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q <= rnd_d;
      widx_q <= widx_d;
      last_q <= last_d;
      final_q <= final_d;
      pad_done_q <= pad_done_d;
    end
  end

  `SHA_NEVER(a_no_accept_busy, clk_i, rst_ni, busy_o && acc)
  `SHA_ASSERT(a_round_wrap, clk_i, rst_ni,
    (state_q == ST_ROUND && rnd_q == 6'd63) |=> state_q == ST_FOLD)
  `SHA_ASSERT(a_emit_eight, clk_i, rst_ni,
    (state_q == ST_EMIT && widx_q == 3'd7) |=> state_q == ST_IDLE)

endmodule

>>> rtl/core/sha_dpath.sv
// datapath of the sha256 hash engine: block buffer, schedule, rounds, chain
// depends on sha_pkg
module sha_dpath
  import sha_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sha_cmd_t   cmd_i,
  input  logic [5:0] round_i,
  input  logic [2:0] widx_i,
  output sha_stat_t  stat_o,
  output logic [31:0] word_o
);

  logic [31:0] w_q [16];      // rolling schedule window, starts as the block
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [60:0] cnt_q;
  logic [5:0]  pos;
  logic [31:0] wt, wnew, s0, s1, t1, t2, big0, big1, ch, maj;

  assign pos = cnt_q[5:0];
  assign stat_o.pos = pos;
  assign word_o = h_q[widx_i];

  // the schedule window shifts every round; w_q[0] is w[t]
  assign wt = w_q[0];
  assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = w_q[0] + s0 + w_q[9] + s1;

  assign big1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign big0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1 = v_q[7] + big1 + ch + ROUND_K[round_i] + wt;
  assign t2 = big0 + maj;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_byte) begin
      w_q[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] <= cmd_i.wbyte;
    end else if (cmd_i.clear_tail) begin
      // pad byte at pos, zeros after; for the second length block, zeros up to the length words
      for (int i = 0; i < 64; i++) begin
        if (!(cmd_i.len_set && i >= 56)) begin
          if (cmd_i.tail_all || i[5:0] > pos) begin
            w_q[i / 4][(3 - i % 4) * 8 +: 8] <= 8'h00;
          end else if (i[5:0] == pos) begin
            w_q[i / 4][(3 - i % 4) * 8 +: 8] <= PAD_BYTE;
          end
        end
      end
      if (cmd_i.len_set) begin
        w_q[14] <= {cnt_q[60:29]};
        w_q[15] <= {cnt_q[28:0], 3'b000};
      end
    end else if (cmd_i.do_round) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= wnew;
    end
    if (cmd_i.load_wv) begin
      v_q <= h_q;
    end else if (cmd_i.do_round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // chain value and byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= INIT_H;
      cnt_q <= '0;
    end else begin
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
      end else if (cmd_i.reset_msg) begin
        h_q <= INIT_H;
      end
      if (cmd_i.count_inc) begin
        cnt_q <= cnt_q + 61'd1;
      end else if (cmd_i.reset_msg) begin
        cnt_q <= '0;
      end
    end
  end

endmodule

>>> rtl/core/sha256_hash_engine_top.sv
// top level of the sha256 hash engine
// depends on sha_pkg, sha_ctrl, sha_dpath and the defines header
//
// channel   | dir | handshake      | payload
// ----------+-----+----------------+-----------------------
// item      | in  | start_i, busy_o| item_i   (sha_in_t)
// result    | out | valid_o strobe | result_o (sha_out_t)
//
// a byte that does not fill a block is taken without leaving idle
// a byte that fills a block runs a compression: load, 64 rounds on the shared round unit, fold
// last item adds a compression per final block (one or two): pad, 64 rounds, fold,
// then eight beats of digest, one per cycle
// reset restores the initial hash values and clears the byte count
// the receiver cannot stall; results go out on fixed cycles
`include "sha256_hash_engine_top_defines.svh"
module sha256_hash_engine_top
  import sha_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  sha_in_t  item_i,
  output logic     busy_o,
  output logic     valid_o,
  output sha_out_t result_o
);

  sha_cmd_t   cmd;
  sha_stat_t  stat;
  logic [5:0] rnd;
  logic [2:0] widx;
  logic [31:0] word;

  // the controller sees pos from the count, which already includes the last byte

  sha_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .stat_i  (stat),
    .busy_o  (busy_o),
    .cmd_o   (cmd),
    .round_o (rnd),
    .widx_o  (widx)
  );

  sha_dpath u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .round_i (rnd),
    .widx_i  (widx),
    .stat_o  (stat),
    .word_o  (word)
  );

  // digest beats straight off the chain register
  assign valid_o = cmd.emit;
  assign result_o.digest_word = word;
  assign result_o.word_index = widx;
  assign result_o.last_word = (widx == 3'd7);

  `SHA_ASSERT(a_beat_idle_in, clk_i, rst_ni, valid_o |-> busy_o)
  `SHA_ASSERT(a_beat_seq, clk_i, rst_ni,
    (valid_o && !result_o.last_word) |=> valid_o)
  `SHA_ASSERT(a_last_ends, clk_i, rst_ni,
    (valid_o && result_o.last_word) |=> !valid_o)

endmodule

>>> verif/tb_sha256_hash_engine_top.sv
// self-checking testbench for the sha256 hash engine top level
// depends on sha_pkg and sha256_hash_engine_top
`timescale 1ns / 100ps
module tb_sha256_hash_engine_top
  import sha_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  sha_in_t  item_i;
  logic     busy_o;
  logic     valid_o;
  sha_out_t result_o;

  sha256_hash_engine_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .item_i(item_i),
    .busy_o(busy_o), .valid_o(valid_o), .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // predictor state: running hash, block being filled, message length
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  logic [60:0] msg_bytes;
  sha_out_t    digest_queue [$];
  int          mismatch_count;
  int          idle_cycles;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of msg_block into hash_state
  task automatic compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic reset_digest_state();
    for (int i = 0; i < 8; i++) hash_state[i] = INIT_H[i];
    msg_bytes = '0;
  endtask

  // apply one accepted beat to the predictor, queue the digest on the last item
  task automatic predict_beat(sha_in_t it);
    int pos;
    logic [63:0] bit_len;
    sha_out_t r;
    if (it.has_byte) begin
      pos = int'(msg_bytes[5:0]);
      msg_block[pos] = it.data_byte;
      msg_bytes = msg_bytes + 1'b1;
      if (pos == 63) compress_msg_block();
    end
    if (it.last_item) begin
      pos = int'(msg_bytes[5:0]);
      bit_len = {msg_bytes, 3'b000};
      msg_block[pos] = PAD_BYTE;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          msg_block[pos] = 8'h00;
          pos++;
        end
        compress_msg_block();
        pos = 0;
      end
      while (pos < 56) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
      compress_msg_block();
      for (int i = 0; i < 8; i++) begin
        r.digest_word = hash_state[i];
        r.word_index = 3'(i);
        r.last_word = (i == 7);
        digest_queue.push_back(r);
      end
      reset_digest_state();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // result monitor: every strobe pops the oldest expected digest word
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected beat", result_o.digest_word, 32'h0);
      end else begin
        automatic sha_out_t want = digest_queue.pop_front();
        if (result_o.digest_word !== want.digest_word)
          report_mismatch("digest_word", result_o.digest_word, want.digest_word);
        if (result_o.word_index !== want.word_index)
          report_mismatch("word_index", 32'(result_o.word_index), 32'(want.word_index));
        if (result_o.last_word !== want.last_word)
          report_mismatch("last_word", 32'(result_o.last_word), 32'(want.last_word));
      end
    end
  end

  // watchdog on cycles with no accepted beat in either direction
  always @(posedge clk_i) begin
    if (!rst_ni || valid_o || (start_i && !busy_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // directed rows: empty message, "abc" with known digest, two one-byte messages
  typedef struct {
    sha_in_t     item;
    logic        known;
    logic [31:0] h0;
  } stim_row_t;

  stim_row_t directed_rows [$];
  sha_in_t   random_items [$];

  function automatic sha_in_t mk(logic [7:0] b, logic h, logic l);
    sha_in_t it;
    it.data_byte = b; it.has_byte = h; it.last_item = l;
    return it;
  endfunction

  // hold the item until accepted; start stays high across back-to-back beats
  task automatic send_beat(sha_in_t it, bit keep_going);
    start_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o);
    predict_beat(it);
    if (!keep_going) start_i <= 1'b0;
  endtask

  task automatic build_message(int len, bit has_tail);
    for (int i = 0; i < len; i++)
      random_items.push_back(mk(8'($urandom_range(0, 255)), 1'b1, 1'b0));
    random_items.push_back(mk(8'($urandom_range(0, 255)), has_tail, 1'b1));
  endtask

  initial begin
    int burst;
    int wait_cycles;
    int len;
    sha_in_t next_item;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    mismatch_count = 0;
    reset_digest_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_rows.push_back('{mk(8'h00, 1'b0, 1'b1), 1'b1, 32'he3b0c442});
    directed_rows.push_back('{mk(8'h61, 1'b1, 1'b0), 1'b0, 32'h0});
    directed_rows.push_back('{mk(8'h00, 1'b0, 1'b0), 1'b0, 32'h0});
    directed_rows.push_back('{mk(8'h62, 1'b1, 1'b0), 1'b0, 32'h0});
    directed_rows.push_back('{mk(8'h63, 1'b1, 1'b1), 1'b1, 32'hba7816bf});
    directed_rows.push_back('{mk(8'hff, 1'b1, 1'b1), 1'b0, 32'h0});
    directed_rows.push_back('{mk(8'h00, 1'b1, 1'b1), 1'b0, 32'h0});

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].item, 1'b1);
      // typed-in first digest word must agree with the predictor
      if (directed_rows[i].known &&
          digest_queue[digest_queue.size()-8].digest_word !== directed_rows[i].h0)
        report_mismatch("known digest", digest_queue[digest_queue.size()-8].digest_word,
                        directed_rows[i].h0);
    end

    // padding edges: 55, 56, 63 and 64 bytes, second block fill across a boundary
    build_message(55, 1'b0);
    build_message(55, 1'b1);
    build_message(63, 1'b0);
    build_message(63, 1'b1);
    // random well-formed messages, mostly short, with empty beats as noise
    while (random_items.size() < 390) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0)
          random_items.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
        random_items.push_back(mk(8'($urandom_range(0, 255)), 1'b1, 1'b0));
      end
      random_items.push_back(mk(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1));
    end

    // sender works in bursts separated by random gaps
    while (random_items.size() > 0) begin
      burst = $urandom_range(1, 16);
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      while (burst > 0 && random_items.size() > 0) begin
        burst--;
        next_item = random_items.pop_front();
        send_beat(next_item, random_items.size() > 0 && (burst > 0 || wait_cycles == 0));
      end
      repeat (wait_cycles) @(posedge clk_i);
    end

    while (digest_queue.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
